[design/assert_macros.svh]
// Assertion macros shared by the trial vector engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[design/dtve_pkg.sv]
// Shared types and constants of the trial vector engine.
`timescale 1ns / 1ps
package dtve_pkg;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// splitmix64 constants.
	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
	localparam int SHIFT_A = 30;
	localparam int SHIFT_B = 27;
	localparam int SHIFT_C = 31;

	// Register reset values.
	localparam logic [15:0] BOUND_LOW_RST = 16'hB000;
	localparam logic [15:0] BOUND_HIGH_RST = 16'h5000;
	localparam logic [16:0] CROSS_RATE_RST = 17'h08000;
	localparam logic [15:0] MUT_FACTOR_RST = 16'h8000;

	localparam logic [47:0] SCORE_MAX = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		REG_BOUND_LOW  = 3'd0,
		REG_BOUND_HIGH = 3'd1,
		REG_CROSS_RATE = 3'd2,
		REG_MUT_FACTOR = 3'd3,
		REG_RNG_SEED   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] bound_low;
		logic [15:0] bound_high;
		logic [16:0] cross_rate;
		logic [15:0] mut_factor;
		logic        seed_load;
		logic [63:0] seed;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_ADD1,
		ST_MUL2,
		ST_ADD2,
		ST_SEL,
		ST_SQR,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic add1;
		logic mul2;
		logic add2;
		logic sel;
		logic sqr;
		logic acc;
	} dp_cmd_t;

endpackage

[design/dtve_cfg.sv]
// APB register file of the trial vector engine.
`timescale 1ns / 1ps
module dtve_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dtve_pkg::ADDR_W-1:0]  paddr,
	input  logic [dtve_pkg::DATA_W-1:0]  pwdata,
	output logic [dtve_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output dtve_pkg::cfg_t               cfg
);
	import dtve_pkg::*;

	logic [15:0] bound_low_q;
	logic [15:0] bound_high_q;
	logic [16:0] cross_rate_q;
	logic [15:0] mut_factor_q;
	logic [63:0] seed_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_low_q  <= BOUND_LOW_RST;
			bound_high_q <= BOUND_HIGH_RST;
			cross_rate_q <= CROSS_RATE_RST;
			mut_factor_q <= MUT_FACTOR_RST;
			seed_q       <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_BOUND_LOW:  bound_low_q  <= pwdata[15:0];
				REG_BOUND_HIGH: bound_high_q <= pwdata[15:0];
				REG_CROSS_RATE: cross_rate_q <= pwdata[16:0];
				REG_MUT_FACTOR: mut_factor_q <= pwdata[15:0];
				REG_RNG_SEED:   seed_q       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BOUND_LOW:  prdata = {48'h0, bound_low_q};
			REG_BOUND_HIGH: prdata = {48'h0, bound_high_q};
			REG_CROSS_RATE: prdata = {47'h0, cross_rate_q};
			REG_MUT_FACTOR: prdata = {48'h0, mut_factor_q};
			REG_RNG_SEED:   prdata = seed_q;
			default:        prdata = '0;
		endcase
	end

	// The seed write reloads the generator state at the same edge.
	assign cfg.bound_low  = bound_low_q;
	assign cfg.bound_high = bound_high_q;
	assign cfg.cross_rate = cross_rate_q;
	assign cfg.mut_factor = mut_factor_q;
	assign cfg.seed_load  = wr_en && (idx == REG_RNG_SEED);
	assign cfg.seed       = pwdata;

endmodule

[design/dtve_ctrl.sv]
// Sequencer state machine and output word handshake of the trial vector engine.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtve_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dtve_pkg::dp_cmd_t cmd
);
	import dtve_pkg::*;

	state_t st_q;
	state_t st_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d     = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				st_d     = ST_ADD1;
			end
			ST_ADD1: begin
				cmd.add1 = 1'b1;
				st_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				st_d     = ST_ADD2;
			end
			ST_ADD2: begin
				cmd.add2 = 1'b1;
				st_d     = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				st_d    = ST_SQR;
			end
			ST_SQR: begin
				cmd.sqr = 1'b1;
				st_d    = ST_ACC;
			end
			ST_ACC: begin
				// Wait here while the output register still holds an untaken word.
				if (!out_valid_q || out_ready) begin
					cmd.acc = 1'b1;
					st_d    = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_load_starts, clk, arst_n, in_valid && in_ready, st_q == ST_MUL1)
	`ASSERT_NEXT(a_acc_emits, clk, arst_n, cmd.acc, out_valid_q && (st_q == ST_IDLE))
	`ASSERT_IMPLY(a_acc_room, clk, arst_n, cmd.acc, !out_valid_q || out_ready)

endmodule

[design/dtve_dp.sv]
// Datapath of the trial vector engine: generator, mutant, clamp, square and score.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtve_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  dtve_pkg::dp_cmd_t cmd,
	input  dtve_pkg::cfg_t    cfg,
	input  logic signed [15:0] base_value,
	input  logic signed [15:0] diff_plus,
	input  logic signed [15:0] diff_minus,
	input  logic signed [15:0] target_value,
	input  logic [47:0]        target_score,
	input  logic               last_element,
	output logic signed [15:0] trial_value,
	output logic               is_last,
	output logic               accepted,
	output logic [47:0]        vector_score
);
	import dtve_pkg::*;

	// Latched input word.
	logic [15:0] x0_q, x1_q, x2_q, xt_q;
	logic [47:0] tscore_q;
	logic        last_q;

	// Generator state and mix pipeline.
	logic [63:0] rng_q;
	logic [63:0] z_q;
	logic [63:0] pp_ll_q;
	logic [31:0] pp_lh_q;
	logic [31:0] pp_hl_q;
	logic [63:0] mix_op;
	logic [63:0] k_op;
	logic [63:0] pp_ll_d;
	logic [31:0] pp_lh_d;
	logic [31:0] pp_hl_d;
	logic [63:0] z_d;
	logic [63:0] rnd;
	logic        take;

	// Mutant path.
	logic signed [16:0] diff;
	logic signed [33:0] prod_d;
	logic signed [33:0] prod_q;
	logic [18:0]        m_q;
	logic [18:0]        lo_ext;
	logic [18:0]        hi_ext;
	logic [15:0]        clamped;
	logic [15:0]        trial_q;

	// Score path.
	logic signed [31:0] sq_full;
	logic [30:0]        sq_q;
	logic [47:0]        score_q;
	logic [48:0]        sum_w;
	logic [47:0]        sum_sat;

	logic signed [15:0] trial_value_q;
	logic               is_last_q;
	logic               accepted_q;
	logic [47:0]        vector_score_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q     <= base_value;
			x1_q     <= diff_plus;
			x2_q     <= diff_minus;
			xt_q     <= target_value;
			tscore_q <= target_score;
			last_q   <= last_element;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= '0;
		end else if (cfg.seed_load) begin
			rng_q <= cfg.seed;
		end else if (cmd.load) begin
			rng_q <= rng_q + GOLDEN;
		end
	end

	// Low 64 bits of a 64x64 product from three 32x32 partial products.
	assign mix_op  = cmd.mul1 ? (rng_q ^ (rng_q >> SHIFT_A)) : (z_q ^ (z_q >> SHIFT_B));
	assign k_op    = cmd.mul1 ? MIX_C1 : MIX_C2;
	assign pp_ll_d = mix_op[31:0] * k_op[31:0];
	assign pp_lh_d = mix_op[31:0] * k_op[63:32];
	assign pp_hl_d = mix_op[63:32] * k_op[31:0];
	assign z_d     = pp_ll_q + {pp_lh_q + pp_hl_q, 32'h0};

	always_ff @(posedge clk) begin
		if (cmd.mul1 || cmd.mul2) begin
			pp_ll_q <= pp_ll_d;
			pp_lh_q <= pp_lh_d;
			pp_hl_q <= pp_hl_d;
		end
		if (cmd.add1 || cmd.add2) begin
			z_q <= z_d;
		end
	end

	assign diff   = $signed({x1_q[15], x1_q}) - $signed({x2_q[15], x2_q});
	assign prod_d = diff * $signed({1'b0, cfg.mut_factor});

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			prod_q <= prod_d;
		end
		// Arithmetic shift by 16 floors the scaled difference.
		if (cmd.add1) begin
			m_q <= {{3{x0_q[15]}}, x0_q} + {prod_q[33], prod_q[33:16]};
		end
	end

	assign lo_ext = {{3{cfg.bound_low[15]}}, cfg.bound_low};
	assign hi_ext = {{3{cfg.bound_high[15]}}, cfg.bound_high};

	always_comb begin
		if ($signed(m_q) < $signed(lo_ext)) begin
			clamped = cfg.bound_low;
		end else if ($signed(m_q) > $signed(hi_ext)) begin
			clamped = cfg.bound_high;
		end else begin
			clamped = m_q[15:0];
		end
	end

	assign rnd  = z_q ^ (z_q >> SHIFT_C);
	assign take = ({1'b0, rnd[63:48]} < cfg.cross_rate);

	assign sq_full = $signed(trial_q) * $signed(trial_q);

	always_ff @(posedge clk) begin
		if (cmd.sel) begin
			trial_q <= take ? clamped : xt_q;
		end
		if (cmd.sqr) begin
			sq_q <= sq_full[30:0];
		end
	end

	assign sum_w   = {1'b0, score_q} + {18'h0, sq_q};
	assign sum_sat = sum_w[48] ? SCORE_MAX : sum_w[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (cmd.acc) begin
			score_q <= last_q ? '0 : sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			trial_value_q  <= trial_q;
			is_last_q      <= last_q;
			accepted_q     <= last_q && (sum_sat < tscore_q);
			vector_score_q <= last_q ? sum_sat : '0;
		end
	end

	assign trial_value  = trial_value_q;
	assign is_last      = is_last_q;
	assign accepted     = accepted_q;
	assign vector_score = vector_score_q;

	`ASSERT_NEXT(a_sum_clear, clk, arst_n, cmd.acc && last_q, score_q == '0)
	`ASSERT_NEXT(a_rng_step, clk, arst_n, cmd.load && !cfg.seed_load, rng_q == $past(rng_q) + GOLDEN)

endmodule

[design/de_trial_vector_engine_core.sv]
// Top level of the differential evolution trial vector engine.
`timescale 1ns / 1ps
// A result word becomes valid once the sequencer has passed its input word through
// two 64-bit generator multiplies, mutant select, squaring and score add. A new
// input word is taken only in idle, after that single pass is through.
// The result wait in an output register does not block the next input word.
// Reset (arst_n low, asynchronous) restores register defaults, zeroes the
// generator state and the score sum, and leaves the block idle.
module de_trial_vector_engine_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB-style configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dtve_pkg::ADDR_W-1:0] paddr,
	input  logic [dtve_pkg::DATA_W-1:0] pwdata,
	output logic [dtve_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// Input word channel.
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          base_value,
	input  logic signed [15:0]          diff_plus,
	input  logic signed [15:0]          diff_minus,
	input  logic signed [15:0]          target_value,
	input  logic [47:0]                 target_score,
	input  logic                        last_element,
	// Result word channel.
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          trial_value,
	output logic                        is_last,
	output logic                        accepted,
	output logic [47:0]                 vector_score
);
	import dtve_pkg::*;

	// Register values and the seed load strobe from the configuration port.
	cfg_t    cfg;
	// One-hot step strobes from the sequencer to the datapath.
	dp_cmd_t cmd;

	// Register file. Registers sit at byte addresses 8*i; a write to the seed
	// register also loads the generator state at the same edge.
	dtve_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer takes one word in idle, walks the datapath through its
	// seven steps and waits in the last step until the output register is free.
	dtve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath advances the splitmix64 state once per word, builds the
	// clamped mutant, picks mutant or target by the crossover draw, and adds
	// the square into the saturating score, which clears after the last word.
	dtve_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.base_value   (base_value),
		.diff_plus    (diff_plus),
		.diff_minus   (diff_minus),
		.target_value (target_value),
		.target_score (target_score),
		.last_element (last_element),
		.trial_value  (trial_value),
		.is_last      (is_last),
		.accepted     (accepted),
		.vector_score (vector_score)
	);

endmodule

[bench/trial_vector_checker.sv]
// Checker that mirrors the trial vector engine and compares every result word.
`timescale 1ns / 1ps
module trial_vector_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [dtve_pkg::ADDR_W-1:0] paddr,
	input  logic [dtve_pkg::DATA_W-1:0] pwdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic signed [15:0]          base_value,
	input  logic signed [15:0]          diff_plus,
	input  logic signed [15:0]          diff_minus,
	input  logic signed [15:0]          target_value,
	input  logic [47:0]                 target_score,
	input  logic                        last_element,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic signed [15:0]          trial_value,
	input  logic                        is_last,
	input  logic                        accepted,
	input  logic [47:0]                 vector_score,
	output int                          mismatch_count,
	output int                          words_in_flight
);
	import dtve_pkg::*;

	localparam logic [63:0] WEYL_STEP  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
	localparam logic [63:0] SCORE_CEIL = 64'h0000_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [15:0] value;
		logic               last;
		logic               better;
		logic [47:0]        score;
	} trial_word_t;

	logic signed [15:0] low_bound;
	logic signed [15:0] high_bound;
	logic [16:0]        cross_rate;
	logic [15:0]        weight;
	logic [63:0]        gen_state;
	logic [63:0]        square_sum;
	trial_word_t        trial_words_due[$];

	initial mismatch_count = 0;

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s is %0h, expected %0h", $time, field, got, want);
		mismatch_count++;
	endtask

	// One splitmix64 draw; the generator moves on for every element.
	function automatic logic [63:0] next_draw();
		logic [63:0] z;
		gen_state = gen_state + WEYL_STEP;
		z = gen_state;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	task automatic build_trial_word();
		logic [63:0]        draw;
		longint             scaled;
		longint             mutant;
		logic signed [15:0] chosen;
		trial_word_t        w;
		draw = next_draw();
		if (draw[63:48] < cross_rate) begin
			scaled = (longint'(diff_plus) - longint'(diff_minus)) * longint'(weight);
			// The arithmetic shift floors negative products.
			mutant = longint'(base_value) + (scaled >>> 16);
			if (mutant < longint'(low_bound))
				mutant = longint'(low_bound);
			else if (mutant > longint'(high_bound))
				mutant = longint'(high_bound);
			chosen = mutant[15:0];
		end else begin
			chosen = target_value;
		end
		square_sum = square_sum + 64'(longint'(chosen) * longint'(chosen));
		if (square_sum > SCORE_CEIL)
			square_sum = SCORE_CEIL;
		w.value = chosen;
		w.last = last_element;
		if (last_element) begin
			w.better = square_sum[47:0] < target_score;
			w.score = square_sum[47:0];
			square_sum = '0;
		end else begin
			w.better = 1'b0;
			w.score = '0;
		end
		trial_words_due.push_back(w);
	endtask

	task automatic check_trial_word();
		trial_word_t w;
		if (trial_words_due.size() == 0) begin
			report_mismatch("unexpected result word, trial_value", {48'b0, trial_value}, '0);
		end else begin
			w = trial_words_due.pop_front();
			if (trial_value !== w.value)
				report_mismatch("trial_value", {48'b0, trial_value}, {48'b0, w.value});
			if (is_last !== w.last)
				report_mismatch("is_last", {63'b0, is_last}, {63'b0, w.last});
			if (accepted !== w.better)
				report_mismatch("accepted", {63'b0, accepted}, {63'b0, w.better});
			if (vector_score !== w.score)
				report_mismatch("vector_score", {16'b0, vector_score}, {16'b0, w.score});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound = -16'sd20480;
			high_bound = 16'sd20480;
			cross_rate = 17'd32768;
			weight = 16'd32768;
			gen_state = '0;
			square_sum = '0;
			trial_words_due.delete();
			words_in_flight <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:3])
					REG_BOUND_LOW:  low_bound = pwdata[15:0];
					REG_BOUND_HIGH: high_bound = pwdata[15:0];
					REG_CROSS_RATE: cross_rate = pwdata[16:0];
					REG_MUT_FACTOR: weight = pwdata[15:0];
					REG_RNG_SEED:   gen_state = pwdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready)
				check_trial_word();
			if (in_valid && in_ready)
				build_trial_word();
			words_in_flight <= trial_words_due.size();
		end
	end

endmodule

[bench/tb_top.sv]
// Testbench top: stimulus, configuration and verdict for the trial vector engine.
`timescale 1ns / 1ps
module tb_top;
	import dtve_pkg::*;

	// Longest run of cycles with no accepted word or register write before
	// the run is declared hung. A correct run stays far below this, even when
	// the longest sender gap, the longest receiver stall and one pass of the
	// sequencer come together.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles allowed after the last result word before the verdict.
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_PHASES = 6;
	localparam int WORDS_PER_PHASE = 66;

	// An address one past the register list; writes there must change nothing.
	localparam logic [2:0] REG_SPARE = 3'd5;

	localparam logic signed [15:0] Q_LOW  = -16'sd20480;
	localparam logic signed [15:0] Q_HIGH = 16'sd20480;
	localparam logic [16:0] CROSS_NEVER  = 17'd0;
	localparam logic [16:0] CROSS_ALWAYS = 17'd65536;
	localparam logic [47:0] SCORE_TOP = 48'hFFFF_FFFF_FFFF;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [15:0]   base_value;
	logic signed [15:0]   diff_plus;
	logic signed [15:0]   diff_minus;
	logic signed [15:0]   target_value;
	logic [47:0]          target_score;
	logic                 last_element;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [15:0]   trial_value;
	logic                 is_last;
	logic                 accepted;
	logic [47:0]          vector_score;

	int mismatch_count;
	int words_in_flight;

	// When set, neither the sender nor the receiver inserts idle cycles.
	bit steady;

	de_trial_vector_engine_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.base_value   (base_value),
		.diff_plus    (diff_plus),
		.diff_minus   (diff_minus),
		.target_value (target_value),
		.target_score (target_score),
		.last_element (last_element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trial_value  (trial_value),
		.is_last      (is_last),
		.accepted     (accepted),
		.vector_score (vector_score)
	);

	// The checker watches both word channels and the register port on its own;
	// this module only makes stimulus and reads back the failure count.
	trial_vector_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.base_value      (base_value),
		.diff_plus       (diff_plus),
		.diff_minus      (diff_minus),
		.target_value    (target_value),
		.target_score    (target_score),
		.last_element    (last_element),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.trial_value     (trial_value),
		.is_last         (is_last),
		.accepted        (accepted),
		.vector_score    (vector_score),
		.mismatch_count  (mismatch_count),
		.words_in_flight (words_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle cycles before a word is offered: usually none or a few, now and
	// then a long pause so that gaps land on every stage of the sequencer.
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic int stall_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 8);
		else
			return $urandom_range(20, 40);
	endfunction

	// Most element values stay inside the Q4.11 range of the design; one in
	// eight is a raw 16-bit pattern so that every bit of every field toggles.
	function automatic logic signed [15:0] random_element();
		int v;
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		v = int'($urandom_range(0, 40960)) - 20480;
		return 16'(v);
	endfunction

	// Vectors are mostly short so that many scores get compared; a few are
	// longer so that the running sum grows large.
	function automatic int vector_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 6);
		else if (r < 95)
			return $urandom_range(7, 20);
		else
			return $urandom_range(21, 60);
	endfunction

	// A typical in-range element squares to about 2^27, so a target score
	// drawn below length * 2^28 lands on either side of the trial score
	// about equally often. One score in four, at random, is a full 48-bit pattern.
	function automatic logic [47:0] random_score(input int len);
		logic [63:0] span;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		span = 64'(len) << 28;
		if ($urandom_range(0, 3) == 0)
			return raw[47:0];
		return 48'(raw % (span + 64'd1));
	endfunction

	// Offer one word and hold it until the engine takes it. Valid stays high
	// from one word to the next when no gap is drawn.
	task automatic put_word(input logic signed [15:0] x0, input logic signed [15:0] x1,
			input logic signed [15:0] x2, input logic signed [15:0] xt,
			input logic [47:0] score, input logic last);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		base_value <= x0;
		diff_plus <= x1;
		diff_minus <= x2;
		target_value <= xt;
		target_score <= score;
		last_element <= last;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// Every word yields exactly one result, so once nothing is in flight the
	// engine is idle and its registers may be rewritten.
	task automatic finish_burst();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_in_flight != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_settings(input logic signed [15:0] low, input logic signed [15:0] high,
			input logic [16:0] rate, input logic [15:0] factor, input logic [63:0] seed);
		write_register(REG_BOUND_LOW, {48'b0, low});
		write_register(REG_BOUND_HIGH, {48'b0, high});
		write_register(REG_CROSS_RATE, {47'b0, rate});
		write_register(REG_MUT_FACTOR, {48'b0, factor});
		write_register(REG_RNG_SEED, seed);
	endtask

	// The receiver is ready for a random run of cycles and then stalls for a
	// random stretch, except while the steady flag asks for a clean stream.
	initial begin : result_sink
		out_ready = 1'b1;
		forever begin
			repeat ($urandom_range(1, 12)) @(negedge clk);
			if (!steady) begin
				out_ready <= 1'b0;
				repeat (stall_length()) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Ends the run when nothing moves on any port for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL de_trial_vector_engine_core");
		$finish;
	end

	initial begin : stimulus
		int                 sent;
		int                 len;
		logic signed [15:0] low;
		logic signed [15:0] high;
		logic signed [15:0] swap;
		logic [16:0]        rate;
		logic [15:0]        factor;

		steady = 1'b1;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		base_value = '0;
		diff_plus = '0;
		diff_minus = '0;
		target_value = '0;
		target_score = '0;
		last_element = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: half crossover, F of one half, the generator at zero.
		put_word(16'sd1000, 16'sd3000, -16'sd2000, 16'sd500, SCORE_TOP, 1'b0);
		put_word(-16'sd4000, 16'sd2048, 16'sd2048, -16'sd7000, 48'd0, 1'b0);
		put_word(Q_HIGH, Q_LOW, Q_HIGH, Q_HIGH, SCORE_TOP, 1'b1);
		finish_burst();

		// Mutant always taken with the largest F: both clamps, then the
		// floor of a negative scaled difference against a positive one, then
		// raw extreme patterns closing a vector whose target score is zero.
		steady = 1'b0;
		load_settings(Q_LOW, Q_HIGH, CROSS_ALWAYS, 16'hFFFF, 64'd0);
		put_word(Q_HIGH, Q_HIGH, Q_LOW, 16'sd0, 48'd0, 1'b0);
		put_word(Q_LOW, Q_LOW, Q_HIGH, 16'sd0, 48'd0, 1'b0);
		put_word(16'sd0, -16'sd1, 16'sd0, 16'sd0, 48'd0, 1'b0);
		put_word(16'sd0, 16'sd1, 16'sd0, 16'sd0, 48'd0, 1'b0);
		put_word(16'sh8000, 16'sh7FFF, 16'sh8000, 16'shFFFF, 48'd0, 1'b1);
		finish_burst();

		// Crossover never: the target passes through. A target score equal
		// to the trial score is not strictly below it; one more is.
		write_register(REG_CROSS_RATE, {47'b0, CROSS_NEVER});
		put_word(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, SCORE_TOP, 1'b0);
		put_word(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, SCORE_TOP, 1'b0);
		put_word(16'sd0, 16'sd0, 16'sd0, Q_LOW,
			48'd1073676289 + 48'd1073741824 + 48'd419430400, 1'b1);
		put_word(16'sd0, 16'sd0, 16'sd0, Q_LOW, 48'd419430401, 1'b1);
		finish_burst();

		// Inverted bounds: anything below the low bound gives the low bound,
		// everything else gives the high bound. A write past the register
		// list must leave the engine untouched.
		load_settings(16'sd100, -16'sd100, CROSS_ALWAYS, 16'd32768, {$urandom, $urandom});
		write_register(REG_SPARE, {$urandom, $urandom});
		put_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, SCORE_TOP, 1'b0);
		put_word(16'sd5000, 16'sd0, 16'sd0, 16'sd0, SCORE_TOP, 1'b0);
		put_word(16'sd100, 16'sd0, 16'sd0, 16'sd0, SCORE_TOP, 1'b0);
		put_word(Q_LOW, Q_HIGH, Q_LOW, 16'sd0, random_score(4), 1'b1);
		finish_burst();

		// Random vectors under a new setting per phase. The first two pin
		// the extremes, including the all-ones pattern of the crossover rate
		// and a zero F; one later phase runs without any idling.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					low = Q_LOW;
					high = Q_HIGH;
					rate = CROSS_ALWAYS;
					factor = 16'hFFFF;
				end
				1: begin
					low = 16'sh8000;
					high = 16'sh7FFF;
					rate = 17'h1FFFF;
					factor = 16'd0;
				end
				default: begin
					low = random_element();
					high = random_element();
					if (low > high && $urandom_range(0, 3) != 0) begin
						swap = low;
						low = high;
						high = swap;
					end
					rate = 17'($urandom_range(0, 65536));
					factor = 16'($urandom);
				end
			endcase
			load_settings(low, high, rate, factor, {$urandom, $urandom});
			steady = (phase == 3);
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				len = vector_length();
				for (int i = 0; i < len; i++)
					put_word(random_element(), random_element(), random_element(),
						random_element(), random_score(len), i == len - 1);
				sent += len;
			end
			finish_burst();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && words_in_flight == 0)
			$display("PASS de_trial_vector_engine_core");
		else
			$display("FAIL de_trial_vector_engine_core");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/dtve_pkg.sv
design/dtve_cfg.sv
design/dtve_ctrl.sv
design/dtve_dp.sv
design/de_trial_vector_engine_core.sv
bench/trial_vector_checker.sv
bench/tb_top.sv
